/* src/lkv_pkg.sv */
// Package for the LRU key-value cache: sizes, command and register codes,
// shared structs and the find-first helper. No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lkv_op_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } lkv_res_t;

  typedef struct packed {
    logic [ENTRIES-1:0] valid;
    logic [CNT_W-1:0]   count;
  } lkv_status_t;

  // lowest set bit position, zero when none is set
  function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

/* src/lkv_regs.sv */
// APB-style configuration register block: holds the capacity register.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_regs
  import lkv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [CAP_W-1:0]  capacity_o
);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             wr_en;
  logic             sel_cap;

  assign pready  = 1'b1;
  assign sel_cap = (paddr[2] == REG_CAPACITY);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cap_d = cap_q;
    if (wr_en && sel_cap) cap_d = pwdata[CAP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata     = sel_cap ? DATA_W'(cap_q) : '0;
  assign capacity_o = cap_q;

endmodule

/* src/lkv_store.sv */
// Entry store of the LRU cache: key/value registers, recency ranks, parallel
// lookup, eviction and insertion for one operation per cycle. Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_store
  import lkv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_vld_i,
  input  lkv_op_t          op_i,
  input  logic [CAP_W-1:0] capacity_i,
  output lkv_res_t         res_o,
  output lkv_status_t      status_o
);

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]   rank_q [ENTRIES];
  logic [IDX_W-1:0]   rank_d [ENTRIES];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [KEY_W-1:0]   key_q [ENTRIES];
  logic [VALUE_W-1:0] value_q [ENTRIES];

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] victim_vec;
  logic [ENTRIES-1:0] valid_ev;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   lru_rank;
  logic [CAP_W-1:0]   cap_sat;
  logic               do_evict;
  logic               wr_key, wr_val;
  logic [IDX_W-1:0]   wr_idx;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == op_i.key);
    end
  end

  assign hit      = |hit_vec;
  assign hit_idx  = first_set(hit_vec);
  assign hit_rank = rank_q[hit_idx];

  // capacity saturates into 1..ENTRIES
  always_comb begin
    if (capacity_i == '0) begin
      cap_sat = CAP_W'(1);
    end else if (capacity_i > CAP_W'(ENTRIES)) begin
      cap_sat = CAP_W'(ENTRIES);
    end else begin
      cap_sat = capacity_i;
    end
  end

  assign do_evict = (count_q >= CNT_W'(cap_sat));

  // ranks of valid entries are distinct, so the LRU one holds count-1
  assign lru_rank = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
    end
  end

  assign valid_ev = do_evict ? (valid_q & ~victim_vec) : valid_q;
  assign slot     = first_set(~valid_ev);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    wr_idx  = hit_idx;
    if (op_vld_i) begin
      if (hit) begin
        // touch: entries more recent than the hit age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (rank_q[i] < hit_rank)) rank_d[i] = rank_q[i] + IDX_W'(1);
        end
        rank_d[hit_idx] = '0;
        wr_val = (op_i.cmd == CMD_PUT);
      end else if (op_i.cmd == CMD_PUT) begin
        valid_d = valid_ev;
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_ev[i]) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end else begin
            rank_d[i] = '0;
          end
        end
        valid_d[slot] = 1'b1;
        rank_d[slot]  = '0;
        if (do_evict) begin
          count_d = count_q;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
        wr_key = 1'b1;
        wr_val = 1'b1;
        wr_idx = slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) key_q[wr_idx] <= op_i.key;
    if (wr_val) value_q[wr_idx] <= op_i.value;
  end

  assign res_o.hit        = hit;
  assign res_o.read_value = (hit && (op_i.cmd == CMD_GET)) ? value_q[hit_idx] : '0;
  assign status_o.valid   = valid_q;
  assign status_o.count   = count_q;

endmodule

/* src/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: operation register, result register,
// config port and the entry store. Depends on lkv_pkg, lkv_regs, lkv_store.
//
// Usage:
//   Operations (cmd_i get/put, key_i, write_value_i) are transferred at a
//   rising edge with start high and busy low. busy is always low, so one
//   operation can be issued every cycle. The operation is registered, then
//   looked up and applied against the 16 entry registers; the next operation
//   sees the updated state. The result (hit_o, read_value_o) is held in the
//   result register, loaded from the lookup on the operation register, and
//   is marked by done_o for exactly one cycle. The receiver cannot stall,
//   so no result is ever held back.
//   Capacity is written through the APB-style port (address 0); the user
//   must do so only while idle, which the block itself does not enforce.
//   It saturates into 1..16 and takes effect on the next insertion.
//   Reset clears all entries, the occupancy count and the recency ranks and
//   sets capacity to 16; no clearing pass is needed.
`timescale 1ns / 1ps

module lru_key_value_cache
  import lkv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VALUE_W-1:0] write_value_i,
  output logic               done_o,
  output logic               hit_o,
  output logic [VALUE_W-1:0] read_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic             op_vld_q;
  lkv_op_t          op_q;
  logic             done_q;
  lkv_res_t         res_q;
  lkv_res_t         res;
  lkv_status_t      status;
  logic [CAP_W-1:0] capacity;
  logic             in_xfer;

  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  lkv_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  lkv_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_vld_i   (op_vld_q),
    .op_i       (op_q),
    .capacity_i (capacity),
    .res_o      (res),
    .status_o   (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      op_vld_q <= in_xfer;
      done_q   <= op_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q.cmd   <= cmd_i;
      op_q.key   <= key_i;
      op_q.value <= write_value_i;
    end
    res_q <= res;
  end

  assign done_o       = done_q;
  assign hit_o        = res_q.hit;
  assign read_value_o = res_q.read_value;

  a_issue_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> ##1 done_o)
    else $error("transferred operation gave no result");

  a_done_has_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(op_vld_q))
    else $error("result without operation");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(status.valid) == int'(status.count))
    else $error("occupancy count out of step with valid entries");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (read_value_o == '0))
    else $error("miss returned non-zero data");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for the LRU key-value cache: directed and random get/put traffic,
// checked against a behavioural LRU store kept in a scoreboard class.
// Depends on lkv_pkg and lru_key_value_cache.

module testbench;
  import lkv_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'(4);

  class lru_scoreboard;
    bit                 valid [ENTRIES];
    logic [KEY_W-1:0]   keys  [ENTRIES];
    logic [VALUE_W-1:0] vals  [ENTRIES];
    int unsigned        age   [ENTRIES];
    int unsigned        used;
    int unsigned        cap = ENTRIES;
    lkv_res_t           expected_q [$];
    int                 errors;

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      // only index 0 exists, other addresses are dropped
      if ((addr >> 2) == ADDR_W'(REG_CAPACITY)) cap = data[CAP_W-1:0];
    endfunction

    function void promote(int idx);
      foreach (valid[i])
        if (valid[i] && age[i] < age[idx]) age[i]++;
      age[idx] = 0;
    endfunction

    function void drop_lru();
      int victim = -1;
      foreach (valid[i])
        if (valid[i] && (victim < 0 || age[i] >= age[victim])) victim = i;
      if (victim >= 0) begin
        valid[victim] = 1'b0;
        age[victim]   = 0;
        if (used > 0) used--;
      end
    endfunction

    function int free_slot();
      foreach (valid[i])
        if (!valid[i]) return i;
      return -1;
    endfunction

    function void note_op(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
      int          found = -1;
      int          slot;
      int unsigned lim;
      lkv_res_t    res;
      foreach (valid[i])
        if (found < 0 && valid[i] && keys[i] == key) found = i;
      res.hit        = (found >= 0);
      res.read_value = '0;
      // capacity saturates into 1..ENTRIES
      lim = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
      if (found >= 0) begin
        if (cmd == CMD_GET) res.read_value = vals[found];
        else vals[found] = value;
        promote(found);
      end else if (cmd == CMD_PUT) begin
        if (used >= lim) drop_lru();
        slot = free_slot();
        if (slot < 0) begin
          drop_lru();
          slot = free_slot();
        end
        if (slot >= 0) begin
          foreach (valid[i])
            if (valid[i]) age[i]++;
          valid[slot] = 1'b1;
          keys[slot]  = key;
          vals[slot]  = value;
          age[slot]   = 0;
          used++;
        end
      end
      expected_q.push_back(res);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic hit, logic [VALUE_W-1:0] rv);
      lkv_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with none expected: hit %b value %h", hit, rv));
        return;
      end
      want = expected_q.pop_front();
      if (hit !== want.hit)
        report($sformatf("hit %b, expected %b", hit, want.hit));
      if (rv !== want.read_value)
        report($sformatf("read_value %h, expected %h", rv, want.read_value));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cmd_i;
  logic [KEY_W-1:0]   key_i;
  logic [VALUE_W-1:0] write_value_i;
  logic               done_o;
  logic               hit_o;
  logic [VALUE_W-1:0] read_value_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  lru_scoreboard sb = new();
  int unsigned   quiet_cycles = 0;

  lru_key_value_cache uut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .key_i, .write_value_i,
    .done_o, .hit_o, .read_value_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_op(cmd_i, key_i, write_value_i);
      if (done_o) sb.check_result(hit_o, read_value_o);
    end
    if (!rst_ni || (start && !busy) || done_o || (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_op(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    start         <= 1'b1;
    cmd_i         <= cmd;
    key_i         <= key;
    write_value_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // start low with junk on the payload, for as long as the caller asks
  task automatic pause(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) begin
      cmd_i         <= 1'($urandom);
      key_i         <= KEY_W'($urandom);
      write_value_i <= VALUE_W'($urandom);
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(addr, data);
  endtask

  initial begin
    logic [KEY_W-1:0]   pool [$];
    int unsigned        cap_plan [$];
    int unsigned        lim;
    int unsigned        sel;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    logic [DATA_W-1:0]  data;

    cap_plan      = '{16, 1, 0, 31, 2, 17, 3, 8, 15};
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    cmd_i         <= CMD_GET;
    key_i         <= '0;
    write_value_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, capacity at its reset value
    send_op(CMD_GET, '0, '0);
    send_op(CMD_PUT, '0, '1);
    send_op(CMD_GET, '0, '0);
    send_op(CMD_PUT, '1, '0);
    send_op(CMD_GET, '1, 32'hA5A5_A5A5);   // get ignores its write value
    send_op(CMD_PUT, '0, 32'h1234_5678);   // update in place
    send_op(CMD_GET, '0, '0);
    send_op(CMD_GET, 32'hDEAD_BEEF, '0);
    write_reg(CAPACITY_ADDR, 2);
    send_op(CMD_PUT, 32'h1, 32'h11);       // full: LRU out, freed slot reused
    send_op(CMD_GET, '1, '0);
    send_op(CMD_GET, '0, '0);
    send_op(CMD_PUT, 32'h2, 32'h22);
    write_reg(CAPACITY_ADDR, 1);           // now below occupancy
    send_op(CMD_PUT, 32'h3, 32'h33);
    send_op(CMD_GET, 32'h2, '0);
    send_op(CMD_GET, 32'h3, '0);
    write_reg(CAPACITY_ADDR, 0);           // behaves as one
    send_op(CMD_PUT, 32'h4, 32'h44);
    send_op(CMD_GET, 32'h3, '0);
    write_reg(SPARE_ADDR, 8);              // no such register
    send_op(CMD_PUT, 32'h5, 32'h55);
    write_reg(CAPACITY_ADDR, '1);          // 31, saturates to sixteen
    send_op(CMD_PUT, 32'h6, '1);
    send_op(CMD_PUT, 32'h7, '0);
    send_op(CMD_GET, 32'h5, '0);

    // random phases, each under its own capacity
    cap_plan.push_back($urandom_range(0, 31));
    foreach (cap_plan[phase]) begin
      data = $urandom;
      data[CAP_W-1:0] = CAP_W'(cap_plan[phase]);
      write_reg(CAPACITY_ADDR, data);
      lim = (cap_plan[phase] == 0) ? 1 :
            (cap_plan[phase] > ENTRIES) ? ENTRIES : cap_plan[phase];
      // key pool slightly larger than the capacity keeps hits and evictions common
      pool.delete();
      repeat (lim + $urandom_range(1, 4)) pool.push_back(KEY_W'($urandom));
      repeat (PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 80)      k = pool[$urandom_range(0, pool.size() - 1)];
        else if (sel < 92) k = KEY_W'($urandom);
        else if (sel < 96) k = '0;
        else               k = '1;
        sel = $urandom_range(0, 9);
        if (sel == 0)      v = '0;
        else if (sel == 1) v = '1;
        else               v = VALUE_W'($urandom);
        send_op($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, v);
        // phase 4 runs back to back
        if (phase != 4 && $urandom_range(0, 99) < 25) pause($urandom_range(1, 3));
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
src/lkv_pkg.sv
src/lkv_regs.sv
src/lkv_store.sv
src/lru_key_value_cache.sv
sim/testbench.sv
